@@ hw/rtl/rde_pkg.sv @@
// Shared types and constants for the radix digit emitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package rde_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int MAX_DIGITS  = 31;
    localparam int RADIX_W     = 8;
    localparam int DIGIT_W     = 8;
    localparam int MIN_RADIX   = 2;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W       = $clog2(MAX_DIGITS);
    localparam int STEP_W      = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_LOAD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [RADIX_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIGIT_W-1:0]     remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ hw/rtl/rde_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on rde_pkg.
`default_nettype none

module rde_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rde_pkg::t_div_req i_req,
    output rde_pkg::t_div_rsp  o_rsp
);
    import rde_pkg::*;

    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [RADIX_W-1:0]     r_rem, n_rem;
    logic [RADIX_W-1:0]     r_div, n_div;
    logic [STEP_W-1:0]      r_step, n_step;
    logic                   r_busy, n_busy;
    logic                   r_done, n_done;

    logic [RADIX_W:0] trial;
    logic [RADIX_W:0] diff;
    logic             fits;

    // partial remainder shifted by one dividend bit
    assign trial = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = trial >= {1'b0, r_div};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo  = {r_quo[VALUE_WIDTH-2:0], fits};
            n_rem  = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(VALUE_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

@@ hw/rtl/rde_stack.sv @@
// Digit stack: one write port, one registered read port.
// Depends on rde_pkg.
`default_nettype none

module rde_stack (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [rde_pkg::IDX_W-1:0]   i_wr_addr,
    input  wire logic [rde_pkg::DIGIT_W-1:0] i_wr_data,
    input  wire logic                        i_rd_en,
    input  wire logic [rde_pkg::IDX_W-1:0]   i_rd_addr,
    output logic      [rde_pkg::DIGIT_W-1:0] o_rd_data
);
    import rde_pkg::*;

    logic [DIGIT_W-1:0] mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hw/rtl/radix_digit_emitter_unit.sv @@
// Top level of the radix digit emitter: sequencer, radix register, output register.
// Depends on rde_pkg, rde_div and rde_stack.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------
//  value   | in        | i_valid / o_ready           | i_value[30:0]
//  digit   | out       | o_valid / i_ready           | o_digit[7:0], o_last_digit
//  config  | in        | i_cfg_valid / o_cfg_ready   | i_cfg_data[7:0] (radix)
//
// Operation: a number with D digits (D = 1..31) is divided by the radix once per
// digit in the shared bit-serial divider, then the stack is popped one digit at a
// time through the read, load and present states.
// Reset is synchronous, active low; radix returns to 2. The stack is not cleared.
// o_ready is high only when idle; output stalls hold the pop sequence.
`default_nettype none

module radix_digit_emitter_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // value request
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [rde_pkg::VALUE_WIDTH-1:0] i_value,
    // digit results
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic      [rde_pkg::DIGIT_W-1:0]     o_digit,
    output logic                                 o_last_digit,
    // radix register write
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rde_pkg::RADIX_W-1:0]     i_cfg_data
);
    import rde_pkg::*;

    t_state             r_state, n_state;
    logic [RADIX_W-1:0] r_radix;
    logic [CNT_W-1:0]   r_count, n_count;   // digits pushed so far
    logic [IDX_W-1:0]   r_pop, n_pop;       // stack entry being played out
    logic               r_out_valid, n_out_valid;
    logic [DIGIT_W-1:0] r_digit, n_digit;
    logic               r_last, n_last;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic               push;
    logic               rd_en;
    logic [DIGIT_W-1:0] rd_data;
    logic [CNT_W-1:0]   count_inc;

    assign count_inc = r_count + 1'b1;

    // --------------------------------------------------------------
    // Radix register; 0 and 1 are forced to 2
    // --------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_W'(MIN_RADIX);
        end else if (i_cfg_valid) begin
            r_radix <= (i_cfg_data inside {[0:MIN_RADIX-1]}) ? RADIX_W'(MIN_RADIX)
                                                              : i_cfg_data;
        end
    end

    // --------------------------------------------------------------
    // Sequencer
    // --------------------------------------------------------------
    always_comb begin
        n_state          = r_state;
        n_count          = r_count;
        n_pop            = r_pop;
        n_out_valid      = r_out_valid;
        n_digit          = r_digit;
        n_last           = r_last;
        div_req.start    = 1'b0;
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = r_radix;
        push             = 1'b0;
        rd_en            = 1'b0;
        o_ready          = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = i_value;
                    n_count          = '0;
                    n_state          = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    // remainder is the next more significant digit
                    push    = 1'b1;
                    n_count = count_inc;
                    if (div_rsp.quotient != '0 && count_inc < CNT_W'(MAX_DIGITS)) begin
                        div_req.start = 1'b1;
                    end else begin
                        n_pop   = r_count[IDX_W-1:0];
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_out_valid = 1'b1;
                n_digit     = rd_data;
                n_last      = (r_pop == '0);
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_out_valid = 1'b0;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pop   = r_pop - 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pop       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pop       <= n_pop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
        r_last  <= n_last;
    end

    // --------------------------------------------------------------
    // Shared divider and digit stack
    // --------------------------------------------------------------
    rde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rde_stack u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (push),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (div_rsp.remainder),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_pop),
        .o_rd_data (rd_data)
    );

    assign o_valid      = r_out_valid;
    assign o_digit      = r_digit;
    assign o_last_digit = r_last;

    // --------------------------------------------------------------
    // Assertions
    // --------------------------------------------------------------
    a_radix_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_radix >= RADIX_W'(MIN_RADIX))
        else $error("radix register below minimum");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> r_count < CNT_W'(MAX_DIGITS))
        else $error("push beyond stack depth");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside division phase");

    a_valid_only_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == S_OUT)
        else $error("result shown outside output state");

    a_pop_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> {1'b0, r_pop} < r_count)
        else $error("pop reads an entry not pushed by this request");

endmodule

`default_nettype wire

@@ sim/radix_digit_emitter_unit_tb.sv @@
// Testbench for radix_digit_emitter_unit: value-to-digit conversion in a programmable radix.
// Depends on rde_pkg and the RTL of the unit; self-checking, no external files.
`timescale 1ns / 100ps

module radix_digit_emitter_unit_tb;

    import rde_pkg::*;

    localparam int QUIET_LIMIT  = 8000;  // cycles with no handshake at all before giving up
    localparam int DRAIN_CYCLES = 1200;  // idle cycles after the last owed digit
    localparam int PHASES       = 12;
    localparam int PER_PHASE    = 30;
    localparam int MAX_PRINTS   = 100;

    // One expected digit as it leaves the unit.
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_digit_res;

    typedef enum logic {
        ROW_RADIX,
        ROW_VALUE
    } t_row_kind;

    // Directed row: a radix write or a value request. n_typed > 0 means the
    // digits are written out here (msb first) instead of being predicted.
    typedef struct packed {
        t_row_kind                   kind;
        logic [VALUE_WIDTH-1:0]      data;
        logic [1:0]                  n_typed;
        logic [0:2][DIGIT_W-1:0]     typed;
    } t_row;

    localparam int N_ROWS = 26;
    localparam t_row DIRECTED [N_ROWS] = '{
        // radix 2 straight out of reset
        '{ROW_VALUE, 31'd0,          2'd1, {8'd0,   8'd0, 8'd0}},  // zero -> single 0
        '{ROW_VALUE, 31'd1,          2'd1, {8'd1,   8'd0, 8'd0}},
        '{ROW_VALUE, 31'd2,          2'd2, {8'd1,   8'd0, 8'd0}},
        '{ROW_VALUE, 31'h7FFF_FFFF,  2'd0, '0},                    // 31 ones, deepest stack
        '{ROW_VALUE, 31'h5555_5555,  2'd0, '0},
        // top radix
        '{ROW_RADIX, 31'd255,        2'd0, '0},
        '{ROW_VALUE, 31'd254,        2'd1, {8'd254, 8'd0, 8'd0}},  // largest single digit
        '{ROW_VALUE, 31'd255,        2'd2, {8'd1,   8'd0, 8'd0}},
        '{ROW_VALUE, 31'd0,          2'd1, {8'd0,   8'd0, 8'd0}},
        '{ROW_VALUE, 31'h7FFF_FFFF,  2'd0, '0},
        // radix 0 and 1 both clamp to 2
        '{ROW_RADIX, 31'd0,          2'd0, '0},
        '{ROW_VALUE, 31'd5,          2'd3, {8'd1,   8'd0, 8'd1}},
        '{ROW_RADIX, 31'd1,          2'd0, '0},
        '{ROW_VALUE, 31'd6,          2'd3, {8'd1,   8'd1, 8'd0}},
        // a few ordinary bases
        '{ROW_RADIX, 31'd10,         2'd0, '0},
        '{ROW_VALUE, 31'd1234567890, 2'd0, '0},
        '{ROW_VALUE, 31'd9,          2'd1, {8'd9,   8'd0, 8'd0}},
        '{ROW_RADIX, 31'd16,         2'd0, '0},
        '{ROW_VALUE, 31'h2AAA_AAAA,  2'd0, '0},
        '{ROW_VALUE, 31'h7FFF_FFFF,  2'd0, '0},
        '{ROW_RADIX, 31'd128,        2'd0, '0},
        '{ROW_VALUE, 31'h1000_0000,  2'd0, '0},                    // exact power of the base
        '{ROW_RADIX, 31'd3,          2'd0, '0},
        '{ROW_VALUE, 31'h7FFF_FFFF,  2'd0, '0},
        '{ROW_RADIX, 31'd254,        2'd0, '0},
        '{ROW_VALUE, 31'd253,        2'd1, {8'd253, 8'd0, 8'd0}}
    };

    // ---------------------------------------------------------------- DUT I/O
    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   o_ready;
    logic [VALUE_WIDTH-1:0] i_value     = '0;
    logic                   o_valid;
    logic                   i_ready     = 1'b0;
    logic [DIGIT_W-1:0]     o_digit;
    logic                   o_last_digit;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [RADIX_W-1:0]     i_cfg_data  = '0;

    radix_digit_emitter_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digit      (o_digit),
        .o_last_digit (o_last_digit),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // ------------------------------------------------------ bookkeeping state
    t_digit_res         digits_due [$];     // digits still owed by the unit, oldest first
    logic [RADIX_W-1:0] radix_setting = RADIX_W'(MIN_RADIX);
    int                 errors        = 0;
    int                 n_values      = 0;
    int                 n_digits      = 0;
    int                 n_radix_wr    = 0;
    int                 burst_left    = 0;
    int                 quiet_cycles  = 0;
    logic [15:0]        ready_pat     = '1;
    logic [5:0]         pat_pos       = '0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // Repeated division by the base, remainders stacked lsb first, then
    // queued msb first. The cap on stack depth never bites at 31 bits.
    function automatic void expand_to_digits(input logic [VALUE_WIDTH-1:0] v,
                                             input logic [RADIX_W-1:0]     base);
        logic [DIGIT_W-1:0]     rems [MAX_DIGITS];
        logic [VALUE_WIDTH-1:0] quo;
        int                     n;
        quo = v;
        n   = 0;
        do begin
            rems[n] = DIGIT_W'(quo % base);
            quo     = quo / base;
            n++;
        end while (quo != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            digits_due.push_back('{rems[k], k == 0});
        end
    endfunction

    // Random value shaped toward the interesting digit counts for this base.
    function automatic logic [VALUE_WIDTH-1:0] pick_value(input logic [RADIX_W-1:0] base);
        longint pw;
        int     steps;
        case ($urandom_range(0, 3))
            0: return VALUE_WIDTH'($urandom);
            1: return VALUE_WIDTH'($urandom_range(0, int'(base) * int'(base)));
            2: begin
                // exact power of the base, or one below it (digit-count edge)
                pw    = 1;
                steps = $urandom_range(1, VALUE_WIDTH);
                for (int k = 0; k < steps; k++) begin
                    if (pw * base <= longint'({VALUE_WIDTH{1'b1}})) pw = pw * base;
                end
                return VALUE_WIDTH'($urandom_range(0, 1) ? pw : pw - 1);
            end
            default: return VALUE_WIDTH'($urandom >> $urandom_range(0, 31));
        endcase
    endfunction

    // Offer one value request and hold it until taken; the sender then
    // either continues its burst or drops valid for a random gap.
    task automatic send_value(input logic [VALUE_WIDTH-1:0]  v,
                              input int                      n_typed = 0,
                              input logic [0:2][DIGIT_W-1:0] typed   = '0);
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        n_values++;
        if (n_typed == 0) begin
            expand_to_digits(v, radix_setting);
        end else begin
            for (int k = 0; k < n_typed; k++) begin
                digits_due.push_back('{typed[k], k == n_typed - 1});
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 6);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    endtask

    // Radix write: only once the unit has handed back every owed digit.
    task automatic write_radix(input logic [RADIX_W-1:0] d);
        i_valid <= 1'b0;
        while (digits_due.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid   <= 1'b0;
        radix_setting  = (d < MIN_RADIX) ? RADIX_W'(MIN_RADIX) : d;
        n_radix_wr++;
    endtask

    // Receiver back-pressure: a 16-bit ready pattern replayed four times,
    // then redrawn; a quarter of the patterns never stall.
    always @(posedge i_clk) begin
        if (pat_pos == 6'd63) begin
            ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end
        pat_pos <= pat_pos + 6'd1;
        i_ready <= ready_pat[pat_pos[3:0]];
    end

    // Digit checker and no-progress watchdog. Signals are read as they
    // stood just before the edge.
    always @(posedge i_clk) begin
        t_digit_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (digits_due.size() == 0) begin
                flag_mismatch($sformatf("digit %0d last=%0b with nothing owed",
                                        o_digit, o_last_digit));
            end else begin
                want = digits_due.pop_front();
                if (o_digit !== want.digit) begin
                    flag_mismatch($sformatf("digit got %0d want %0d", o_digit, want.digit));
                end
                if (o_last_digit !== want.last) begin
                    flag_mismatch($sformatf("last flag got %0b want %0b (digit %0d)",
                                            o_last_digit, want.last, want.digit));
                end
                n_digits++;
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d digits owed",
                     QUIET_LIMIT, digits_due.size());
            $display("radix_digit_emitter_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------- stimulus
    initial begin
        logic [RADIX_W-1:0] base;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: extremes, clamped radix writes, zero, exact powers
        for (int r = 0; r < N_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_RADIX) begin
                write_radix(RADIX_W'(DIRECTED[r].data));
            end else begin
                send_value(DIRECTED[r].data, DIRECTED[r].n_typed, DIRECTED[r].typed);
            end
        end

        // random phases, each under its own radix; the first ones pin the ends
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       base = 8'd2;
                1:       base = 8'd255;
                2:       base = 8'd1;
                3:       base = 8'd0;
                default: base = RADIX_W'($urandom_range(0, 255));
            endcase
            write_radix(base);
            for (int i = 0; i < PER_PHASE; i++) begin
                send_value(pick_value(radix_setting));
            end
        end

        i_valid <= 1'b0;
        while (digits_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d value requests, %0d digits checked, %0d radix writes",
                 n_values, n_digits, n_radix_wr);
        $display("bases included 2, 255, clamped 0/1 and random picks; %0d errors", errors);
        if (errors == 0) begin
            $display("radix_digit_emitter_unit: match");
        end else begin
            $display("radix_digit_emitter_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rde_pkg.sv
hw/rtl/rde_div.sv
hw/rtl/rde_stack.sv
hw/rtl/radix_digit_emitter_unit.sv
sim/radix_digit_emitter_unit_tb.sv
